>>> rtl/idf_pkg.sv
package idf_pkg;

    localparam int MAX_FIELD_DEF = 63;
    localparam int QUEUE_DEPTH   = 2;

    localparam int VALUE_W     = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DD_W        = BCD_W + VALUE_W;
    localparam int BITS_PER_CY = 4;
    localparam int CONV_CYCLES = VALUE_W / BITS_PER_CY;
    localparam int CONV_CNT_W  = $clog2(CONV_CYCLES);

    localparam logic [1:0] SZ_FULL  = 2'd0;
    localparam logic [1:0] SZ_SHORT = 2'd1;
    localparam logic [1:0] SZ_CHAR  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CONV,
        F_PLAN,
        F_SIZE,
        F_PUSH
    } t_fstate;

endpackage

>>> rtl/idf_fifo.sv
module idf_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [DW-1:0] i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_avail,
    output logic [DW-1:0] o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_avail;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/idf_front.sv
module idf_front #(
    parameter int MAX_FIELD = idf_pkg::MAX_FIELD_DEF,
    parameter int CW        = $clog2(MAX_FIELD + 2)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [31:0]              i_value_bits,
    input  logic                     i_is_signed,
    input  logic [1:0]               i_size_mode,
    input  logic [5:0]               i_field_width,
    input  logic                     i_has_precision,
    input  logic [5:0]               i_precision_digits,
    input  logic                     i_left_justify,
    input  logic                     i_zero_pad,
    output logic                     o_qwr,
    input  logic                     i_qfull,
    output logic [idf_pkg::BCD_W-1:0] o_digits,
    output logic [CW-1:0]            o_b1,
    output logic [CW-1:0]            o_b2,
    output logic [CW-1:0]            o_b3,
    output logic [CW-1:0]            o_b4,
    output logic [CW-1:0]            o_b5,
    output logic [CW-1:0]            o_n,
    output logic                     o_zpad
);
    localparam logic [31:0] MAXF = 32'(MAX_FIELD);

    idf_pkg::t_fstate r_state, n_state;

    logic [idf_pkg::DD_W-1:0]       r_dd;
    logic [idf_pkg::CONV_CNT_W-1:0] r_cnt;
    logic                           r_neg, r_hasp, r_left, r_zpad;
    logic [CW-1:0]                  r_width, r_prec;
    logic [3:0]                     r_len;
    logic [CW-1:0]                  r_b1, r_b2, r_b3, r_b4, r_b5, r_n;

    logic                     accept;
    logic [31:0]              raw, mag;
    logic                     neg;
    logic [CW-1:0]            width_c, prec_c;
    logic [idf_pkg::DD_W-1:0] dd_next;
    logic [3:0]               len;
    logic                     zero;
    logic [CW-1:0]            prec_eff;
    logic [CW-1:0]            body, mx, b5, b3, b4, b2, ndig;
    logic                     mid;

    // one shift-add-3 step of the binary to BCD conversion
    function automatic logic [idf_pkg::DD_W-1:0] dd_step(input logic [idf_pkg::DD_W-1:0] v);
        logic [idf_pkg::DD_W-1:0] t;
        t = v;
        for (int k = 0; k < idf_pkg::NUM_DIGITS; k++) begin
            if (t[idf_pkg::VALUE_W + 4*k +: 4] >= 4'd5) begin
                t[idf_pkg::VALUE_W + 4*k +: 4] = t[idf_pkg::VALUE_W + 4*k +: 4] + 4'd3;
            end
        end
        return {t[idf_pkg::DD_W-2:0], 1'b0};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idf_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_full  = 1'b1;
        o_qwr   = 1'b0;
        accept  = 1'b0;
        unique case (r_state)
            idf_pkg::F_IDLE: begin
                o_full = 1'b0;
                accept = i_push;
                if (i_push) begin
                    n_state = idf_pkg::F_CONV;
                end
            end
            idf_pkg::F_CONV: begin
                if (r_cnt == idf_pkg::CONV_CNT_W'(idf_pkg::CONV_CYCLES - 1)) begin
                    n_state = idf_pkg::F_PLAN;
                end
            end
            idf_pkg::F_PLAN: n_state = idf_pkg::F_SIZE;
            idf_pkg::F_SIZE: n_state = idf_pkg::F_PUSH;
            idf_pkg::F_PUSH: begin
                o_qwr = !i_qfull;
                if (!i_qfull) begin
                    n_state = idf_pkg::F_IDLE;
                end
            end
            default: n_state = idf_pkg::F_IDLE;
        endcase
    end

    // narrowing, sign and magnitude, and clamping of width and precision
    always_comb begin
        unique case (i_size_mode)
            idf_pkg::SZ_SHORT: raw = {{16{i_is_signed & i_value_bits[15]}}, i_value_bits[15:0]};
            idf_pkg::SZ_CHAR:  raw = {{24{i_is_signed & i_value_bits[7]}}, i_value_bits[7:0]};
            default:           raw = i_value_bits;
        endcase
        neg     = i_is_signed & raw[31];
        mag     = neg ? (32'd0 - raw) : raw;
        width_c = ({26'd0, i_field_width} > MAXF) ? CW'(MAX_FIELD) : CW'(i_field_width);
        prec_c  = ({26'd0, i_precision_digits} > MAXF) ? CW'(MAX_FIELD)
                                                      : CW'(i_precision_digits);
    end

    always_comb begin
        dd_next = r_dd;
        for (int s = 0; s < idf_pkg::BITS_PER_CY; s++) begin
            dd_next = dd_step(dd_next);
        end
    end

    always_comb begin
        len = 4'd1;
        for (int k = 0; k < idf_pkg::NUM_DIGITS; k++) begin
            if (r_dd[idf_pkg::VALUE_W + 4*k +: 4] != 4'd0) begin
                len = 4'(k + 1);
            end
        end
        zero = (r_dd[idf_pkg::DD_W-1:idf_pkg::VALUE_W] == '0);
        if (r_hasp) begin
            prec_eff = (r_prec < CW'(len) && !zero) ? CW'(len) : r_prec;
        end else begin
            prec_eff = CW'(len);
        end
    end

    // region boundaries: sign first, pad, sign, zeros, digits, trailing pad
    always_comb begin
        body = r_prec + CW'(r_neg);
        mx   = (r_width > body) ? r_width : body;
        b5   = r_left ? body : mx;
        b3   = b5 - r_prec;
        ndig = (r_prec != '0) ? CW'(r_len) : '0;
        b4   = b5 - ndig;
        mid  = r_neg & ~r_left & ~r_zpad;
        b2   = b3 - CW'(mid);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dd    <= {{idf_pkg::BCD_W{1'b0}}, mag};
            r_cnt   <= '0;
            r_neg   <= neg;
            r_width <= width_c;
            r_prec  <= prec_c;
            r_hasp  <= i_has_precision;
            r_left  <= i_left_justify;
            r_zpad  <= i_zero_pad;
        end
        if (r_state == idf_pkg::F_CONV) begin
            r_dd  <= dd_next;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == idf_pkg::F_PLAN) begin
            r_len  <= len;
            r_prec <= prec_eff;
            r_zpad <= r_zpad & ~r_hasp;
        end
        if (r_state == idf_pkg::F_SIZE) begin
            r_b1 <= CW'(r_neg & (r_left | r_zpad));
            r_b2 <= b2;
            r_b3 <= b3;
            r_b4 <= b4;
            r_b5 <= b5;
            r_n  <= mx;
        end
    end

    assign o_digits = r_dd[idf_pkg::DD_W-1:idf_pkg::VALUE_W];
    assign o_b1     = r_b1;
    assign o_b2     = r_b2;
    assign o_b3     = r_b3;
    assign o_b4     = r_b4;
    assign o_b5     = r_b5;
    assign o_n      = r_n;
    assign o_zpad   = r_zpad;

endmodule

>>> rtl/idf_back.sv
module idf_back #(
    parameter int MAX_FIELD = idf_pkg::MAX_FIELD_DEF,
    parameter int CW        = $clog2(MAX_FIELD + 2)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    output logic                      o_qtake,
    input  logic                      i_qavail,
    input  logic [idf_pkg::BCD_W-1:0] i_digits,
    input  logic [CW-1:0]             i_b1,
    input  logic [CW-1:0]             i_b2,
    input  logic [CW-1:0]             i_b3,
    input  logic [CW-1:0]             i_b4,
    input  logic [CW-1:0]             i_b5,
    input  logic [CW-1:0]             i_n,
    input  logic                      i_zpad,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [7:0]                o_out_char,
    output logic                      o_is_last
);
    logic [CW-1:0] r_pos;
    logic          r_ovalid;
    logic [7:0]    r_char;
    logic          r_last;

    logic       slot_free, emit, skip, last, take;
    logic [3:0] didx;
    logic [3:0] dval;
    logic [7:0] ch;

    assign slot_free = !r_ovalid || i_pop;
    assign skip      = i_qavail && (i_n == '0);
    assign emit      = i_qavail && slot_free && (i_n != '0);
    assign last      = (CW'(r_pos + 1'b1) == i_n);
    assign take      = skip || (emit && last);
    assign o_qtake   = take;

    // digits are stored least significant first
    assign didx = 4'(i_b5 - r_pos - CW'(1));

    always_comb begin
        dval = 4'd0;
        for (int k = 0; k < idf_pkg::NUM_DIGITS; k++) begin
            if (didx == 4'(k)) begin
                dval = i_digits[4*k +: 4];
            end
        end
    end

    always_comb begin
        priority if (r_pos < i_b1) begin
            ch = idf_pkg::CH_MINUS;
        end else if (r_pos < i_b2) begin
            ch = i_zpad ? idf_pkg::CH_ZERO : idf_pkg::CH_SPACE;
        end else if (r_pos < i_b3) begin
            ch = idf_pkg::CH_MINUS;
        end else if (r_pos < i_b4) begin
            ch = idf_pkg::CH_ZERO;
        end else if (r_pos < i_b5) begin
            ch = idf_pkg::CH_ZERO | {4'd0, dval};
        end else begin
            ch = idf_pkg::CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_pos <= '0;
            end else if (emit) begin
                r_pos <= r_pos + 1'b1;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= ch;
            r_last <= last;
        end
    end

    assign o_empty    = !r_ovalid;
    assign o_out_char = r_char;
    assign o_is_last  = r_last;

endmodule

>>> rtl/integer_decimal_formatter_top.sv
// Channel   Handshake          Payload
// input     i_push / o_full    i_value_bits, i_is_signed, i_size_mode, i_field_width,
//                              i_has_precision, i_precision_digits, i_left_justify,
//                              i_zero_pad
// result    o_empty / i_pop    o_out_char, o_is_last (one character per word)
//
// Front end: accept, 4-bit shift-add-3 BCD conversion, the planning states F_PLAN and F_SIZE,
// one push into the two-entry job queue that waits while the queue is full; a new item is taken only in idle.
// Back end: one character per cycle while the output slot is free or being popped; an item has
// max(field_width, sign + max(precision, digits)) characters; an item with no characters
// is dropped from the queue without output.
// Reset is synchronous and active low; there is no clearing pass.
// Holding off pop stalls only the back end; the front keeps converting until the queue fills.
module integer_decimal_formatter_top #(
    parameter int MAX_FIELD = idf_pkg::MAX_FIELD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_value_bits,
    input  logic        i_is_signed,
    input  logic [1:0]  i_size_mode,
    input  logic [5:0]  i_field_width,
    input  logic        i_has_precision,
    input  logic [5:0]  i_precision_digits,
    input  logic        i_left_justify,
    input  logic        i_zero_pad,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_char,
    output logic        o_is_last
);
    localparam int CW = $clog2(MAX_FIELD + 2);
    localparam int DW = idf_pkg::BCD_W + 6 * CW + 1;

    logic                      qwr, qfull;
    logic [idf_pkg::BCD_W-1:0] f_digits, b_digits;
    logic [CW-1:0]             f_b1, f_b2, f_b3, f_b4, f_b5, f_n;
    logic [CW-1:0]             b_b1, b_b2, b_b3, b_b4, b_b5, b_n;
    logic                      f_zpad, b_zpad;
    logic [DW-1:0]             q_wdata, q_rdata;
    logic                      q_avail, q_take;

    idf_front #(
        .MAX_FIELD (MAX_FIELD),
        .CW        (CW)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_value_bits       (i_value_bits),
        .i_is_signed        (i_is_signed),
        .i_size_mode        (i_size_mode),
        .i_field_width      (i_field_width),
        .i_has_precision    (i_has_precision),
        .i_precision_digits (i_precision_digits),
        .i_left_justify     (i_left_justify),
        .i_zero_pad         (i_zero_pad),
        .o_qwr              (qwr),
        .i_qfull            (qfull),
        .o_digits           (f_digits),
        .o_b1               (f_b1),
        .o_b2               (f_b2),
        .o_b3               (f_b3),
        .o_b4               (f_b4),
        .o_b5               (f_b5),
        .o_n                (f_n),
        .o_zpad             (f_zpad)
    );

    assign q_wdata = {f_digits, f_b1, f_b2, f_b3, f_b4, f_b5, f_n, f_zpad};
    assign {b_digits, b_b1, b_b2, b_b3, b_b4, b_b5, b_n, b_zpad} = q_rdata;

    idf_fifo #(
        .DW    (DW),
        .DEPTH (idf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (qwr),
        .i_wdata (q_wdata),
        .o_full  (qfull),
        .i_rd    (q_take),
        .o_avail (q_avail),
        .o_rdata (q_rdata)
    );

    idf_back #(
        .MAX_FIELD (MAX_FIELD),
        .CW        (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_qtake     (q_take),
        .i_qavail    (q_avail),
        .i_digits    (b_digits),
        .i_b1        (b_b1),
        .i_b2        (b_b2),
        .i_b3        (b_b3),
        .i_b4        (b_b4),
        .i_b5        (b_b5),
        .i_n         (b_n),
        .i_zpad      (b_zpad),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_char  (o_out_char),
        .o_is_last   (o_is_last)
    );

endmodule

>>> rtl/idf_checker.sv
module idf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_push,
    input logic       o_full,
    input logic       i_pop,
    input logic       o_empty,
    input logic [7:0] o_out_char,
    input logic       o_is_last
);

    // a waiting word holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_char) && $stable(o_is_last)))
        else $error("result word changed while waiting");

    // only digits, minus and space ever leave the block
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_out_char >= idf_pkg::CH_ZERO && o_out_char <= idf_pkg::CH_NINE)
                      || o_out_char == idf_pkg::CH_MINUS || o_out_char == idf_pkg::CH_SPACE))
        else $error("illegal character");

    // the converter is busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> o_full)
        else $error("input taken while converter busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("outputs not cleared by reset");

endmodule

bind integer_decimal_formatter_top idf_checker u_idf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_push     (i_push),
    .o_full     (o_full),
    .i_pop      (i_pop),
    .o_empty    (o_empty),
    .o_out_char (o_out_char),
    .o_is_last  (o_is_last)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CY    = 7;
    localparam int RAND_PHASE  = 100;
    localparam int DRAIN_CY    = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [31:0] value;
        logic        sgn;
        logic [1:0]  size;
        logic [5:0]  width;
        logic        has_prec;
        logic [5:0]  prec;
        logic        left;
        logic        zpad;
    } t_fmt_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_push             = 1'b0;
    logic [31:0] i_value_bits       = '0;
    logic        i_is_signed        = 1'b0;
    logic [1:0]  i_size_mode        = idf_pkg::SZ_FULL;
    logic [5:0]  i_field_width      = '0;
    logic        i_has_precision    = 1'b0;
    logic [5:0]  i_precision_digits = '0;
    logic        i_left_justify     = 1'b0;
    logic        i_zero_pad         = 1'b0;
    logic        i_pop              = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [7:0]  o_out_char;
    logic        o_is_last;

    t_char       char_q[$];
    int          errors        = 0;
    int          cycle_cnt     = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    t_fmt_req    dir_req[$];
    bit          dir_typed[$];
    string       dir_txt[$];

    integer_decimal_formatter_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_value_bits       (i_value_bits),
        .i_is_signed        (i_is_signed),
        .i_size_mode        (i_size_mode),
        .i_field_width      (i_field_width),
        .i_has_precision    (i_has_precision),
        .i_precision_digits (i_precision_digits),
        .i_left_justify     (i_left_justify),
        .i_zero_pad         (i_zero_pad),
        .o_empty            (o_empty),
        .i_pop              (i_pop),
        .o_out_char         (o_out_char),
        .o_is_last          (o_is_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("integer_decimal_formatter_top test failed");
            $finish;
        end
    end

    // queue the text of one conversion, one word per character
    function automatic void queue_text(input byte unsigned txt[$]);
        for (int k = 0; k < txt.size(); k++) begin
            char_q.push_back('{ch: txt[k], last: (k == txt.size() - 1)});
        end
    endfunction

    function automatic void expect_literal(input string s);
        byte unsigned txt[$];
        for (int k = 0; k < s.len(); k++) begin
            txt.push_back(s[k]);
        end
        queue_text(txt);
    endfunction

    function automatic void predict_decimal(input t_fmt_req r);
        logic [31:0]  raw;
        logic [31:0]  mag;
        bit           neg;
        bit           zpad;
        byte unsigned dig[12];
        byte unsigned txt[$];
        int           nd;
        int           prec;
        int           body;
        int           pad;
        raw = r.value;
        case (r.size)
            idf_pkg::SZ_SHORT: begin
                raw = {{16{r.sgn & raw[15]}}, raw[15:0]};
            end
            idf_pkg::SZ_CHAR: begin
                raw = {{24{r.sgn & raw[7]}}, raw[7:0]};
            end
            default: begin
            end
        endcase
        neg = r.sgn && raw[31];
        mag = neg ? -raw : raw;
        nd  = 0;
        do begin
            dig[nd] = idf_pkg::CH_ZERO + 8'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        zpad = r.zpad;
        if (r.has_prec) begin
            zpad = 1'b0;
            prec = int'(r.prec);
            if (prec < nd && raw != 0) begin
                prec = nd;
            end
        end else begin
            prec = nd;
        end
        body = prec + (neg ? 1 : 0);
        pad  = (int'(r.width) > body) ? int'(r.width) - body : 0;
        if (neg && (r.left || zpad)) begin
            txt.push_back(idf_pkg::CH_MINUS);
        end
        if (!r.left) begin
            repeat (pad) txt.push_back(zpad ? idf_pkg::CH_ZERO : idf_pkg::CH_SPACE);
            if (neg && !zpad) begin
                txt.push_back(idf_pkg::CH_MINUS);
            end
        end
        // zero value at precision zero prints no digits at all
        if (prec != 0) begin
            repeat (prec - nd) txt.push_back(idf_pkg::CH_ZERO);
            for (int k = nd - 1; k >= 0; k--) begin
                txt.push_back(dig[k]);
            end
        end
        if (r.left) begin
            repeat (pad) txt.push_back(idf_pkg::CH_SPACE);
        end
        queue_text(txt);
    endfunction

    function automatic void add_row(input logic [31:0] value, input bit sgn,
                                    input logic [1:0] size, input int width,
                                    input bit has_prec, input int prec,
                                    input bit left, input bit zpad,
                                    input bit typed, input string txt);
        dir_req.push_back('{value: value, sgn: sgn, size: size, width: 6'(width),
                            has_prec: has_prec, prec: 6'(prec), left: left, zpad: zpad});
        dir_typed.push_back(typed);
        dir_txt.push_back(txt);
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'($urandom_range(0, 999));
            1: v = -32'($urandom_range(1, 1000));
            2: v = '0;
            3: begin
                case ($urandom_range(0, 7))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h0000_8000;
                    4: v = 32'h0000_7FFF;
                    5: v = 32'h0000_0080;
                    6: v = 32'h0000_007F;
                    default: v = 32'hFFFF_FF80;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // mostly short fields, now and then the full range
    function automatic logic [5:0] pick_field();
        if ($urandom_range(0, 7) == 0) begin
            return 6'($urandom_range(0, 63));
        end
        return 6'($urandom_range(0, 14));
    endfunction

    function automatic t_fmt_req random_req();
        t_fmt_req r;
        r.value    = pick_value();
        r.sgn      = 1'($urandom_range(0, 1));
        r.size     = 2'($urandom_range(0, 3));
        r.width    = pick_field();
        r.has_prec = 1'($urandom_range(0, 1));
        r.prec     = pick_field();
        r.left     = 1'($urandom_range(0, 1));
        r.zpad     = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send_word(input t_fmt_req r, input bit typed, input string txt);
        i_push             <= 1'b1;
        i_value_bits       <= r.value;
        i_is_signed        <= r.sgn;
        i_size_mode        <= r.size;
        i_field_width      <= r.width;
        i_has_precision    <= r.has_prec;
        i_precision_digits <= r.prec;
        i_left_justify     <= r.left;
        i_zero_pad         <= r.zpad;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (typed) begin
            expect_literal(txt);
        end else begin
            predict_decimal(r);
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_push       <= 1'b0;
            i_value_bits <= $urandom;
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        i_pop <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_chars
        t_char want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (char_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("unexpected word: char %h last %b", o_out_char, o_is_last);
                end
            end else begin
                want = char_q.pop_front();
                if (o_out_char !== want.ch || o_is_last !== want.last) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display("mismatch: char %h last %b, expected char %h last %b",
                                 o_out_char, o_is_last, want.ch, want.last);
                    end
                end
            end
        end
    end

    initial begin
        //      value          sgn size               w  prec? p  left zpad typed text
        add_row(32'h0000_0000, 0, idf_pkg::SZ_FULL,   0,  0,  0, 0, 0, 1, "0");
        add_row(32'h0000_0000, 1, idf_pkg::SZ_FULL,   0,  1,  0, 0, 0, 1, "");
        add_row(32'h0000_0000, 0, idf_pkg::SZ_FULL,   5,  1,  0, 0, 0, 1, "     ");
        add_row(32'h0000_0000, 1, idf_pkg::SZ_FULL,   3,  1,  0, 1, 1, 0, "");
        add_row(32'h8000_0000, 1, idf_pkg::SZ_FULL,   0,  0,  0, 0, 0, 1, "-2147483648");
        add_row(32'hFFFF_FFFF, 0, idf_pkg::SZ_FULL,   0,  0,  0, 0, 0, 1, "4294967295");
        add_row(32'hFFFF_FFFF, 1, idf_pkg::SZ_FULL,   0,  0,  0, 0, 0, 1, "-1");
        add_row(32'h7FFF_FFFF, 1, idf_pkg::SZ_FULL,   0,  0,  0, 0, 0, 1, "2147483647");
        add_row(32'h1234_8000, 1, idf_pkg::SZ_SHORT,  0,  0,  0, 0, 0, 1, "-32768");
        add_row(32'h1234_FFFF, 0, idf_pkg::SZ_SHORT,  0,  0,  0, 0, 0, 1, "65535");
        add_row(32'hABCD_EF80, 1, idf_pkg::SZ_CHAR,   0,  0,  0, 0, 0, 1, "-128");
        add_row(32'hABCD_EF80, 0, idf_pkg::SZ_CHAR,   0,  0,  0, 0, 0, 1, "128");
        add_row(32'hFFFF_FFFF, 1, 2'd3,               4,  0,  0, 0, 1, 0, "");
        add_row(32'hFFFF_FFD6, 1, idf_pkg::SZ_FULL,   8,  0,  0, 0, 1, 1, "-0000042");
        add_row(32'hFFFF_FFD6, 1, idf_pkg::SZ_FULL,   8,  0,  0, 0, 0, 1, "     -42");
        add_row(32'hFFFF_FFD6, 1, idf_pkg::SZ_FULL,   8,  0,  0, 1, 0, 1, "-42     ");
        add_row(32'hFFFF_FFD6, 1, idf_pkg::SZ_FULL,   8,  0,  0, 1, 1, 1, "-42     ");
        add_row(32'h0000_002A, 1, idf_pkg::SZ_FULL,   8,  1,  5, 0, 1, 1, "   00042");
        add_row(32'h0000_0007, 0, idf_pkg::SZ_FULL,   0,  1,  3, 0, 0, 1, "007");
        add_row(32'h0000_3039, 1, idf_pkg::SZ_FULL,   0,  1,  2, 0, 0, 1, "12345");
        add_row(32'h8000_0000, 0, idf_pkg::SZ_FULL,  12,  0,  0, 0, 1, 1, "002147483648");
        add_row(32'hFFFF_FF9C, 0, idf_pkg::SZ_CHAR,   6,  0,  0, 0, 1, 0, "");
        add_row(32'h0000_0001, 0, idf_pkg::SZ_FULL,  63,  0,  0, 1, 0, 0, "");
        add_row(32'hFFFF_FFFF, 1, idf_pkg::SZ_FULL,  63,  1, 63, 0, 1, 0, "");
        add_row(32'h8000_0000, 1, idf_pkg::SZ_FULL,  63,  0,  0, 0, 1, 0, "");

        repeat (RESET_CY) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 6;
        recv_idle_pct = 59;
        foreach (dir_req[i]) begin
            send_word(dir_req[i], dir_typed[i], dir_txt[i]);
        end
        repeat (RAND_PHASE) send_word(random_req(), 1'b0, "");

        send_idle_pct = 59;
        recv_idle_pct = 6;
        repeat (RAND_PHASE) send_word(random_req(), 1'b0, "");

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RAND_PHASE) send_word(random_req(), 1'b0, "");
        i_push <= 1'b0;

        while (char_q.size() != 0) @(posedge i_clk);
        // let any conversion that yields no characters clear the pipe
        repeat (DRAIN_CY) @(posedge i_clk);

        if (errors == 0 && char_q.size() == 0) begin
            $display("integer_decimal_formatter_top test passed");
        end else begin
            $display("integer_decimal_formatter_top test failed");
        end
        $finish;
    end

endmodule
